@@ rtl/e2c_pkg.sv @@
// Shared types, constants and small tables for the epoch-to-calendar block.
// No dependencies; imported by e2c_sub_unit and epoch_seconds_to_calendar_unit.
package e2c_pkg;

    localparam int SEC_W     = 32;
    localparam int DVD_W     = 31;   // clamped count is never negative
    localparam int RCP_W     = 32;   // reciprocal constants
    localparam int PROD_W    = DVD_W + RCP_W;
    localparam int RCP_SH    = 37;   // common product shift of every reciprocal
    localparam int QUO_W     = PROD_W - RCP_SH;
    localparam int REM_W     = 16;   // remainder of the widest divisor
    localparam int OPA_W     = REM_W + 1;
    localparam int CNT_W     = 2;
    localparam int YEAR_W    = 11;
    localparam int DAYC_W    = 9;    // day of year, 1..366
    localparam int HRS_DAY_W = 14;   // hours left after the year walk
    localparam int DAY_SH    = DVD_W - HRS_DAY_W;

    localparam logic [REM_W-1:0]  SEC_PER_MIN       = 16'd60;
    localparam logic [REM_W-1:0]  HOURS_PER_DAY     = 16'd24;
    localparam logic [REM_W-1:0]  HOURS_PER_SPAN    = 16'd35064;  // 1461 days
    localparam logic [REM_W-1:0]  HOURS_COMMON_YEAR = 16'd8760;   // 365 days
    localparam logic [YEAR_W-1:0] BASE_YEAR         = 11'd1970;

    // floor(x / d) = (x * ceil(2^37 / d)) >> 37 over the range each division sees
    localparam logic [RCP_W-1:0] RCP_MIN  = 32'h8888_8889;  // 1/60, x < 2^31
    localparam logic [RCP_W-1:0] RCP_SPAN = 32'd3919660;    // 1/35064, x < 2^20
    // 1/24 scaled by 2^20; the hours go in shifted up by DAY_SH
    localparam logic [RCP_W-1:0] RCP_DAY  = 32'd43691;

    localparam logic [CNT_W-1:0] YEAR_WALK = 2'd3;

    localparam logic [3:0] MON_JAN = 4'd0;
    localparam logic [3:0] MON_FEB = 4'd1;
    localparam logic [3:0] MON_DEC = 4'd11;
    localparam logic [DAYC_W-1:0] LEAP_DAY = 9'd60;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_SEC,
        ST_REM_SEC,
        ST_DIV_MIN,
        ST_REM_MIN,
        ST_DIV_SPAN,
        ST_REM_SPAN,
        ST_YEAR,
        ST_DIV_DAY,
        ST_REM_DAY,
        ST_MONTH_ADJ,
        ST_MONTH,
        ST_FINISH
    } e2c_state_t;

    typedef struct packed {
        logic             ge;
        logic [REM_W-1:0] diff;
    } e2c_sub_res_t;

    function automatic logic [4:0] month_len(input logic [3:0] mon);
        logic [4:0] len;
        unique case (mon)
            4'd1:                       len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:    len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [REM_W-1:0] year_hours(input logic [YEAR_W-1:0] yr);
        return (yr[1:0] == 2'b00) ? (HOURS_COMMON_YEAR + HOURS_PER_DAY) : HOURS_COMMON_YEAR;
    endfunction

endpackage

@@ rtl/e2c_sub_unit.sv @@
// Shared compare-and-subtract unit: a >= b and a - b.
// Depends on e2c_pkg.
module e2c_sub_unit (
    input  logic [e2c_pkg::OPA_W-1:0] a,
    input  logic [e2c_pkg::REM_W-1:0] b,
    output e2c_pkg::e2c_sub_res_t     res
);
    import e2c_pkg::*;

    logic [OPA_W:0] d_full;

    assign d_full   = {1'b0, a} - {2'b00, b};
    assign res.ge   = ~d_full[OPA_W];
    assign res.diff = d_full[REM_W-1:0];

endmodule

@@ rtl/epoch_seconds_to_calendar_unit.sv @@
// Top level: seconds since 1970 to calendar date and time of day.
// Depends on e2c_pkg and e2c_sub_unit.
//
//   channel | ports                               | dir | handshake
//   input   | s_seconds                           | in  | s_valid / s_ready
//   result  | m_second m_minute m_hour m_day       | out | m_valid / m_ready
//           | m_month m_year                      |     |
//
// A request passes from acceptance to the result register through three
// reciprocal divisions (multiply, then subtract the product back), one to
// three year steps, the hour/day split, a month set-up step, up to twelve
// month steps (none on a leap day) and a finish step. Remainders, years and
// months share one compare-subtract unit.
// s_ready is high only while the sequencer is idle; a finished result sits
// in the output register, so a new request may start while it is stalled.
// Reset (aresetn, synchronous) clears the sequencer and m_valid.
module epoch_seconds_to_calendar_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [31:0]          s_seconds,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [5:0]                  m_second,
    output logic [5:0]                  m_minute,
    output logic [4:0]                  m_hour,
    output logic [4:0]                  m_day,
    output logic [3:0]                  m_month,
    output logic [10:0]                 m_year
);
    import e2c_pkg::*;

    e2c_state_t state_reg, state_next;

    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [REM_W-1:0]  hrs_reg, hrs_next;
    logic [5:0]        sec_reg, sec_next;
    logic [5:0]        min_reg, min_next;
    logic [4:0]        hour_reg, hour_next;
    logic [DAYC_W-1:0] day_reg, day_next;
    logic [3:0]        mon_reg, mon_next;
    logic [YEAR_W-1:0] year_reg, year_next;

    logic              m_valid_reg, m_valid_next;
    logic [5:0]        m_second_reg, m_second_next;
    logic [5:0]        m_minute_reg, m_minute_next;
    logic [4:0]        m_hour_reg, m_hour_next;
    logic [4:0]        m_day_reg, m_day_next;
    logic [3:0]        m_month_reg, m_month_next;
    logic [YEAR_W-1:0] m_year_reg, m_year_next;

    logic [OPA_W-1:0]  unit_a;
    logic [REM_W-1:0]  unit_b;
    e2c_sub_res_t      unit_res;

    logic [DVD_W-1:0]  mul_a;
    logic [RCP_W-1:0]  mul_m;
    logic [PROD_W-1:0] mul_prod;
    logic [QUO_W-1:0]  q_mul;
    logic [REM_W-1:0]  rem_div;
    logic [REM_W-1:0]  rem_sub;

    logic [REM_W-1:0]  hrs_sel;
    logic              last_step;
    logic              leap;
    logic              in_acc;
    logic              out_free;
    logic              month_more;

    e2c_sub_unit u_sub (
        .a   (unit_a),
        .b   (unit_b),
        .res (unit_res)
    );

    assign s_ready    = (state_reg == ST_IDLE);
    assign in_acc     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign last_step  = (cnt_reg == 2'd1);
    assign leap       = (year_reg[1:0] == 2'b00);

    assign hrs_sel    = unit_res.ge ? unit_res.diff : hrs_reg;
    assign month_more = (mon_reg < MON_DEC) && unit_res.ge && (unit_res.diff != '0);

    // reciprocal multiply for the quotient, then quotient * divisor for the remainder
    always_comb begin
        mul_a   = dvd_reg;
        mul_m   = RCP_MIN;
        rem_div = SEC_PER_MIN;
        unique case (state_reg)
            ST_DIV_SPAN, ST_REM_SPAN: begin
                mul_m   = RCP_SPAN;
                rem_div = HOURS_PER_SPAN;
            end
            ST_DIV_DAY, ST_REM_DAY: begin
                mul_a   = {hrs_reg[HRS_DAY_W-1:0], {DAY_SH{1'b0}}};
                mul_m   = RCP_DAY;
                rem_div = HOURS_PER_DAY;
            end
            default: begin
                mul_a   = dvd_reg;
                mul_m   = RCP_MIN;
                rem_div = SEC_PER_MIN;
            end
        endcase
    end

    assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_m);
    assign q_mul    = mul_prod[PROD_W-1:RCP_SH];
    // low bits only: the remainder is below the divisor, so it is exact mod 2^16
    assign rem_sub  = quo_reg[REM_W-1:0] * rem_div;

    // operand selection for the shared unit
    always_comb begin
        unit_a = '0;
        unit_b = '0;
        unique case (state_reg)
            ST_REM_SEC, ST_REM_MIN, ST_REM_SPAN: begin
                unit_a = {1'b0, dvd_reg[REM_W-1:0]};
                unit_b = rem_sub;
            end
            ST_REM_DAY: begin
                unit_a = {1'b0, hrs_reg};
                unit_b = rem_sub;
            end
            ST_YEAR: begin
                unit_a = {1'b0, hrs_reg};
                unit_b = year_hours(year_reg);
            end
            ST_MONTH: begin
                unit_a = {{(OPA_W-DAYC_W){1'b0}}, day_reg};
                unit_b = {{(REM_W-5){1'b0}}, month_len(mon_reg)};
            end
            default: begin
                unit_a = '0;
                unit_b = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_acc) state_next = ST_DIV_SEC;
            ST_DIV_SEC:   state_next = ST_REM_SEC;
            ST_REM_SEC:   state_next = ST_DIV_MIN;
            ST_DIV_MIN:   state_next = ST_REM_MIN;
            ST_REM_MIN:   state_next = ST_DIV_SPAN;
            ST_DIV_SPAN:  state_next = ST_REM_SPAN;
            ST_REM_SPAN:  state_next = ST_YEAR;
            ST_YEAR:      if (!unit_res.ge || last_step) state_next = ST_DIV_DAY;
            ST_DIV_DAY:   state_next = ST_REM_DAY;
            ST_REM_DAY:   state_next = ST_MONTH_ADJ;
            ST_MONTH_ADJ: begin
                if (leap && day_reg == LEAP_DAY) state_next = ST_FINISH;
                else                             state_next = ST_MONTH;
            end
            ST_MONTH:     if (!month_more) state_next = ST_FINISH;
            ST_FINISH:    if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        dvd_next      = dvd_reg;
        quo_next      = quo_reg;
        cnt_next      = cnt_reg;
        hrs_next      = hrs_reg;
        sec_next      = sec_reg;
        min_next      = min_reg;
        hour_next     = hour_reg;
        day_next      = day_reg;
        mon_next      = mon_reg;
        year_next     = year_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_second_next = m_second_reg;
        m_minute_next = m_minute_reg;
        m_hour_next   = m_hour_reg;
        m_day_next    = m_day_reg;
        m_month_next  = m_month_reg;
        m_year_next   = m_year_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    dvd_next = s_seconds[SEC_W-1] ? '0 : s_seconds[DVD_W-1:0];
                end
            end
            ST_DIV_SEC, ST_DIV_MIN, ST_DIV_SPAN, ST_DIV_DAY: begin
                quo_next = q_mul;
            end
            ST_REM_SEC: begin
                sec_next = unit_res.diff[5:0];
                dvd_next = {{(DVD_W-QUO_W){1'b0}}, quo_reg};
            end
            ST_REM_MIN: begin
                min_next = unit_res.diff[5:0];
                dvd_next = {{(DVD_W-QUO_W){1'b0}}, quo_reg};
            end
            ST_REM_SPAN: begin
                hrs_next  = unit_res.diff;
                year_next = BASE_YEAR + {4'b0, quo_reg[4:0], 2'b00};
                cnt_next  = YEAR_WALK;
            end
            ST_YEAR: begin
                hrs_next = hrs_sel;
                cnt_next = cnt_reg - 2'd1;
                if (unit_res.ge) year_next = year_reg + 11'd1;
            end
            ST_REM_DAY: begin
                hour_next = unit_res.diff[4:0];
                day_next  = quo_reg[DAYC_W-1:0] + 9'd1;
            end
            ST_MONTH_ADJ: begin
                if (leap && day_reg == LEAP_DAY) begin
                    mon_next = MON_FEB;
                    day_next = 9'd29;
                end else begin
                    mon_next = MON_JAN;
                    if (leap && day_reg > LEAP_DAY) day_next = day_reg - 9'd1;
                end
            end
            ST_MONTH: begin
                if (month_more) begin
                    day_next = unit_res.diff[DAYC_W-1:0];
                    mon_next = mon_reg + 4'd1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_second_next = sec_reg;
                    m_minute_next = min_reg;
                    m_hour_next   = hour_reg;
                    m_day_next    = day_reg[4:0];
                    m_month_next  = mon_reg;
                    m_year_next   = year_reg;
                end
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg      <= dvd_next;
        quo_reg      <= quo_next;
        hrs_reg      <= hrs_next;
        sec_reg      <= sec_next;
        min_reg      <= min_next;
        hour_reg     <= hour_next;
        day_reg      <= day_next;
        mon_reg      <= mon_next;
        year_reg     <= year_next;
        m_second_reg <= m_second_next;
        m_minute_reg <= m_minute_next;
        m_hour_reg   <= m_hour_next;
        m_day_reg    <= m_day_next;
        m_month_reg  <= m_month_next;
        m_year_reg   <= m_year_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_second = m_second_reg;
    assign m_minute = m_minute_reg;
    assign m_hour   = m_hour_reg;
    assign m_day    = m_day_reg;
    assign m_month  = m_month_reg;
    assign m_year   = m_year_reg;

    a_year_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_YEAR |-> cnt_reg != '0)
        else $error("step counter ran out inside the year walk");

    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == ST_DIV_SEC)
        else $error("accepted request did not start the seconds division");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result raised outside the finish step");

    a_month_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MONTH |-> (mon_reg <= MON_DEC && day_reg != '0))
        else $error("month walk out of range");

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_hour_reg < 5'd24 && m_minute_reg < 6'd60 &&
                         m_second_reg < 6'd60 && m_day_reg != 5'd0))
        else $error("time of day out of range on result");

endmodule

@@ tb/epoch_seconds_to_calendar_unit_tb.sv @@
// Self-checking testbench for epoch_seconds_to_calendar_unit: directed and random requests,
// with random idling on both channels and a scoreboard that predicts each calendar result.
// Depends only on the RTL top level epoch_seconds_to_calendar_unit.

typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [10:0] year;
} calendar_date_t;

class calendar_scoreboard;
    localparam int unsigned HOURS_PER_SPAN    = 1461 * 24;
    localparam int unsigned COMMON_YEAR_HOURS = 365 * 24;
    localparam int unsigned FIRST_YEAR        = 1970;
    localparam int unsigned JANUARY           = 0;
    localparam int unsigned FEBRUARY          = 1;
    localparam int unsigned DECEMBER          = 11;
    localparam int unsigned LEAP_DAY_OF_YR    = 60;
    localparam int          REPORT_LIMIT      = 10;

    calendar_date_t pending_dates[$];
    int unsigned    mismatches = 0;

    function calendar_date_t seconds_to_date(logic signed [31:0] raw);
        int unsigned    t;
        int unsigned    yr;
        int unsigned    yhours;
        int unsigned    dy;
        int unsigned    mon;
        int unsigned    month_days [12];
        calendar_date_t d;
        month_days = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        t = raw[31] ? 0 : unsigned'(raw);   // negative counts clamp to the epoch
        d.second = 6'(t % 60);
        t = t / 60;
        d.minute = 6'(t % 60);
        t = t / 60;
        yr = FIRST_YEAR + 4 * (t / HOURS_PER_SPAN);
        t = t % HOURS_PER_SPAN;
        // once a step fails the year stays put, so later steps fail too
        repeat (3) begin
            yhours = COMMON_YEAR_HOURS + ((yr % 4 == 0) ? 24 : 0);
            if (t >= yhours) begin
                t -= yhours;
                yr++;
            end
        end
        d.hour = 5'(t % 24);
        dy = t / 24 + 1;
        if (yr % 4 == 0 && dy == LEAP_DAY_OF_YR) begin
            mon = FEBRUARY;
            dy = 29;
        end else begin
            if (yr % 4 == 0 && dy > LEAP_DAY_OF_YR)
                dy--;
            mon = JANUARY;
            while (mon < DECEMBER && dy > month_days[mon]) begin
                dy -= month_days[mon];
                mon++;
            end
        end
        d.day = 5'(dy);
        d.month = 4'(mon);
        d.year = 11'(yr);
        return d;
    endfunction

    function void note_seconds(logic signed [31:0] raw);
        pending_dates.push_back(seconds_to_date(raw));
    endfunction

    function void check_date(calendar_date_t got);
        calendar_date_t want;
        if (pending_dates.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: result %0d-%0d-%0d %0d:%0d:%0d with no request pending", $realtime,
                         got.year, got.month, got.day, got.hour, got.minute, got.second);
        end else begin
            want = pending_dates.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: expected %0d-%0d-%0d %0d:%0d:%0d, got %0d-%0d-%0d %0d:%0d:%0d",
                             $realtime, want.year, want.month, want.day, want.hour, want.minute,
                             want.second, got.year, got.month, got.day, got.hour, got.minute,
                             got.second);
            end
        end
    endfunction
endclass

module epoch_seconds_to_calendar_unit_tb;
    localparam int unsigned STALL_LIMIT    = 5000;
    localparam int          ITEMS_PER_PASS = 367;
    localparam int unsigned SECS_PER_DAY   = 86400;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_seconds = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic [5:0]         m_second;
    logic [5:0]         m_minute;
    logic [4:0]         m_hour;
    logic [4:0]         m_day;
    logic [3:0]         m_month;
    logic [10:0]        m_year;

    int unsigned        src_idle_pct  = 13;
    int unsigned        sink_idle_pct = 57;
    int unsigned        quiet_cycles  = 0;
    calendar_scoreboard dates = new();

    epoch_seconds_to_calendar_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_seconds (s_seconds),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_second  (m_second),
        .m_minute  (m_minute),
        .m_hour    (m_hour),
        .m_day     (m_day),
        .m_month   (m_month),
        .m_year    (m_year)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic send_seconds(input logic signed [31:0] v);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_valid <= 1'b1;
        s_seconds <= v;
        do @(posedge aclk); while (!s_ready);
        dates.note_seconds(v);
    endtask

    // result side: check, stall at random, and watch for a hung block
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                dates.check_date({m_second, m_minute, m_hour, m_day, m_month, m_year});
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("epoch_seconds_to_calendar_unit_tb failed");
                $finish;
            end
        end
        m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    initial begin
        logic signed [31:0] directed [$];
        logic signed [31:0] v;
        int unsigned        yrs;
        directed = '{32'sh8000_0000, -32'sd1, 32'sd0, 32'sd1, 32'sd59, 32'sd60, 32'sd3599,
                     32'sd3600, 32'sd86399, 32'sd86400,
                     32'sd31535999, 32'sd31536000,     // end of 1970
                     32'sd36633599,                    // 28 Feb in a common year
                     32'sd63071999, 32'sd63072000,     // into the first leap year
                     32'sd68169599, 32'sd68169600,     // leap day itself
                     32'sd68255999, 32'sd68256000,     // day after the leap day
                     32'sd94608000, 32'sd94694399,     // 31 Dec of a leap year
                     32'sd126230399, 32'sd126230400,   // four-year span boundary
                     32'sd951782400, 32'sh7FFF_FFFF};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i])
            send_seconds(directed[i]);

        for (int pass = 0; pass < 3; pass++) begin
            if (pass == 1) begin
                src_idle_pct = 57;
                sink_idle_pct = 13;
            end else if (pass == 2) begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            repeat (ITEMS_PER_PASS) begin
                case ($urandom_range(0, 7))
                    0: v = $urandom();
                    1: v = $urandom_range(0, 24854) * SECS_PER_DAY
                           + ($urandom_range(0, 1) ? SECS_PER_DAY - 1 : 0);
                    2: v = (730 + 1461 * $urandom_range(0, 16) + $urandom_range(57, 60))
                           * SECS_PER_DAY + $urandom_range(0, SECS_PER_DAY - 1);
                    3: begin
                        // around new year: leap days before the year are (yrs + 1) / 4
                        yrs = $urandom_range(1, 68);
                        v = (365 * yrs + (yrs + 1) / 4) * SECS_PER_DAY - 1 + $urandom_range(0, 2);
                    end
                    default: v = $urandom_range(0, 32'h7FFF_FFFF);
                endcase
                send_seconds(v);
            end
        end
        s_valid <= 1'b0;

        while (dates.pending_dates.size() != 0)
            @(posedge aclk);
        repeat (150) @(posedge aclk);

        if (dates.mismatches == 0)
            $display("epoch_seconds_to_calendar_unit_tb passed");
        else
            $display("epoch_seconds_to_calendar_unit_tb failed");
        $finish;
    end
endmodule
